// ===== hw/rtl/csc_pkg.sv =====
// Package for the connected subgraph counter: types, constants and bit helpers.
`default_nettype none
package csc_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned RowW     = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned BudgetW  = 32;
  localparam int unsigned CountW   = 33;
  localparam int unsigned CfgW     = 32;

  localparam logic       FuncLoad    = 1'b0;
  localparam logic       FuncStart   = 1'b1;
  localparam logic [0:0] RegBudget   = 1'b0;
  localparam logic [0:0] RegNodeCnt  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT_START,
    S_SCAN,
    S_PUSH,
    S_TOP,
    S_POP_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [RowW-1:0] nodes;
    logic [RowW-1:0] excluded;
    logic [RowW-1:0] frontier;
    logic [RowW-1:0] subset;
  } stk_entry_t;

  function automatic logic [RowW-1:0] low_mask(input logic [CntW-1:0] n);
    logic [RowW:0] t;
    t = (({{RowW{1'b0}}, 1'b1}) << n) - 1'b1;
    return t[RowW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] lsb_index(input logic [RowW-1:0] m);
    logic [IdxW-1:0] r;
    r = '0;
    for (int k = RowW - 1; k >= 0; k--) begin
      if (m[k]) r = IdxW'(k);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/connected_subgraph_counter.sv =====
// Top level: budgeted connected induced subgraph counter over a stored adjacency graph.
// Load transfer: busy stays low; the row is written to the adjacency RAM.
// Start transfer: busy through the single result strobe, which the receiver cannot stall;
//   each counted set is counted, one RAM read issued per node, the reads drained and the
//   set pushed; each exhausted level is popped, each start node advanced, and a final
//   check precedes the strobe; the next transfer is taken after the strobe.
// Reset clears control, budget to all ones and node count to zero; RAMs stay undefined.
`default_nettype none
module connected_subgraph_counter (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire                          func_i,
  input  wire  [csc_pkg::IdxW-1:0]     node_index_i,
  input  wire  [csc_pkg::RowW-1:0]     neighbor_mask_i,
  input  wire                          cfg_we_i,
  input  wire  [0:0]                   cfg_idx_i,
  input  wire  [csc_pkg::CfgW-1:0]     cfg_data_i,
  output logic                         done_o,
  output logic [csc_pkg::CountW-1:0]   subgraph_count_o,
  output logic                         over_budget_o
);
  import csc_pkg::*;

  logic [RowW-1:0]    adj_mem [MaxNodes];
  stk_entry_t         stk_mem [MaxNodes];

  state_e             state_q, state_d;
  logic [BudgetW-1:0] budget_q;
  logic [CntW-1:0]    node_cnt_q;
  logic [CntW-1:0]    start_q, start_d;
  logic [CntW-1:0]    depth_q, depth_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               over_q, over_d;
  stk_entry_t         top_q, top_d;
  logic [RowW-1:0]    set_q, set_d;
  logic [RowW-1:0]    ign_q, ign_d;
  logic [RowW-1:0]    scan_q, scan_d;
  logic [RowW-1:0]    acc_q, acc_d;
  logic               rd_vld_q, rd_vld_d;
  logic [RowW-1:0]    adj_rdata_q;
  stk_entry_t         stk_rdata_q;

  logic [CntW-1:0]    n_eff;
  logic [RowW-1:0]    n_mask;
  logic               adj_re;
  logic [IdxW-1:0]    adj_raddr;
  logic               stk_we, stk_re;
  logic [IdxW-1:0]    stk_waddr, stk_raddr;
  logic [CountW-1:0]  count_inc;
  logic               count_over;
  logic [RowW-1:0]    nb;
  logic [RowW-1:0]    sub_next;

  assign n_eff      = (node_cnt_q > CntW'(MaxNodes)) ? CntW'(MaxNodes) : node_cnt_q;
  assign n_mask     = low_mask(n_eff);
  assign count_inc  = count_q + 1'b1;
  assign count_over = count_inc > {1'b0, budget_q};
  assign nb         = acc_q & ~ign_q & n_mask;
  assign sub_next   = ((top_q.subset | ~top_q.frontier) + 1'b1) & top_q.frontier;

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start && func_i == FuncLoad) begin
      adj_mem[node_index_i] <= neighbor_mask_i;
    end
    if (adj_re) begin
      adj_rdata_q <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= top_q;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      budget_q   <= '1;
      node_cnt_q <= '0;
      start_q    <= '0;
      depth_q    <= '0;
      count_q    <= '0;
      over_q     <= 1'b0;
      rd_vld_q   <= 1'b0;
      top_q      <= '0;
      set_q      <= '0;
      ign_q      <= '0;
      scan_q     <= '0;
      acc_q      <= '0;
    end else begin
      state_q  <= state_d;
      start_q  <= start_d;
      depth_q  <= depth_d;
      count_q  <= count_d;
      over_q   <= over_d;
      rd_vld_q <= rd_vld_d;
      top_q    <= top_d;
      set_q    <= set_d;
      ign_q    <= ign_d;
      scan_q   <= scan_d;
      acc_q    <= acc_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegBudget:  budget_q   <= cfg_data_i[BudgetW-1:0];
          RegNodeCnt: node_cnt_q <= cfg_data_i[CntW-1:0];
          default:    ;
        endcase
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    start_d   = start_q;
    depth_d   = depth_q;
    count_d   = count_q;
    over_d    = over_q;
    rd_vld_d  = 1'b0;
    top_d     = top_q;
    set_d     = set_q;
    ign_d     = ign_q;
    scan_d    = scan_q;
    acc_d     = acc_q;
    adj_re    = 1'b0;
    adj_raddr = lsb_index(scan_q);
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = IdxW'(depth_q - 1'b1);
    stk_raddr = IdxW'(depth_q - 2'd2);
    busy      = state_q != S_IDLE;
    done_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start && func_i == FuncStart) begin
          count_d = '0;
          start_d = '0;
          depth_d = '0;
          over_d  = 1'b0;
          state_d = S_NEXT_START;
        end
      end
      S_NEXT_START: begin
        if (start_q >= n_eff) begin
          state_d = S_DONE;
        end else begin
          count_d = count_inc;
          if (count_over) begin
            over_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            set_d   = {{(RowW-1){1'b0}}, 1'b1} << start_q[IdxW-1:0];
            ign_d   = low_mask(start_q);
            scan_d  = ({{(RowW-1){1'b0}}, 1'b1} << start_q[IdxW-1:0]) & n_mask;
            acc_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_vld_q) acc_d = acc_q | adj_rdata_q;
        if (scan_q != '0) begin
          adj_re   = 1'b1;
          scan_d   = scan_q & (scan_q - 1'b1);
          rd_vld_d = 1'b1;
        end else if (!rd_vld_q) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (nb != '0 && depth_q < CntW'(MaxNodes)) begin
          stk_we         = depth_q != '0;
          top_d.nodes    = set_q;
          top_d.excluded = ign_q | nb | set_q;
          top_d.frontier = nb;
          top_d.subset   = '0;
          depth_d        = depth_q + 1'b1;
        end
        state_d = S_TOP;
      end
      S_TOP: begin
        if (depth_q == '0) begin
          start_d = start_q + 1'b1;
          state_d = S_NEXT_START;
        end else if (top_q.subset == top_q.frontier) begin
          depth_d = depth_q - 1'b1;
          if (depth_q > CntW'(1)) begin
            stk_re  = 1'b1;
            state_d = S_POP_WAIT;
          end
        end else begin
          top_d.subset = sub_next;
          count_d      = count_inc;
          if (count_over) begin
            over_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            set_d   = top_q.nodes | sub_next;
            ign_d   = top_q.excluded;
            scan_d  = (top_q.nodes | sub_next) & n_mask;
            acc_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_POP_WAIT: begin
        top_d   = stk_rdata_q;
        state_d = S_TOP;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign subgraph_count_o = count_q;
  assign over_budget_o    = over_q;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a run");
  a_over_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && over_budget_o) |-> (subgraph_count_o == {1'b0, budget_q} + 1'b1))
    else $error("over-budget result is not budget plus one");
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CntW'(MaxNodes))
    else $error("stack depth overflow");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FuncStart) |=> busy)
    else $error("start transfer did not launch a run");

endmodule
`default_nettype wire
